// ----- rtl/i2a_pkg.sv -----
// i2a_pkg: shared constants, types and the character function of the
// integer to ascii formatter. No dependencies.
package i2a_pkg;

  // width of the converted word and derived digit counts
  localparam int WORD_BITS  = 32;
  localparam int DEC_DIGITS = (WORD_BITS * 3) / 10 + 2;
  localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DIG_BITS   = NDIG * 4;
  localparam int STEP_W     = $clog2(WORD_BITS + 1);
  localparam int REM_W      = $clog2(NDIG + 1);

  // format selector codes
  localparam logic [1:0] FUNC_DEC       = 2'd0;
  localparam logic [1:0] FUNC_HEX_LOWER = 2'd1;

  // ascii codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_UPPER = 7'h41;
  localparam logic [6:0] CH_LOWER = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // sequencer commands to the digit unit and output register
  typedef struct packed {
    logic load;
    logic step;
    logic shift;
    logic out_load;
    logic out_minus;
    logic out_last;
  } ctl_t;

  // digit unit status back to the sequencer
  typedef struct packed {
    logic dec;
    logic neg;
    logic top_zero;
  } stat_t;

  // ascii code of one digit, letters in the chosen case
  function automatic logic [6:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [6:0] base;
    base = upper ? CH_UPPER : CH_LOWER;
    if (nib < 4'd10) begin
      digit_char = CH_ZERO + {3'd0, nib};
    end else begin
      digit_char = base + {3'd0, nib} - 7'd10;
    end
  endfunction

endpackage

// ----- rtl/i2a_conv.sv -----
// i2a_conv: digit register with the shared shift-add-3 unit; converts a
// binary magnitude to bcd one bit per step, or loads hex nibbles directly.
// Depends on i2a_pkg.
module i2a_conv (
  input  logic                       clk,
  input  logic                       rst,
  input  i2a_pkg::ctl_t              ctl,
  input  logic [1:0]                 func,
  input  logic [31:0]                value_bits,
  output i2a_pkg::stat_t             stat,
  output logic [3:0]                 top_nib,
  output logic                       upper
);
  import i2a_pkg::*;

  logic [WORD_BITS-1:0]       word;
  logic [WORD_BITS-1:0]       mag;
  logic                       word_neg;
  logic [WORD_BITS-1:0]       bin;
  logic [NDIG-1:0][3:0]       digits;
  logic [NDIG-1:0][3:0]       adj;
  logic                       neg;
  logic                       dec;

  // input word, sign and magnitude
  assign word     = WORD_BITS'(value_bits);
  assign word_neg = (func == FUNC_DEC) && word[WORD_BITS-1];
  assign mag      = word_neg ? (~word + 1'b1) : word;

  // add 3 to every bcd digit of 5 or more
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? (digits[i] + 4'd3) : digits[i];
    end
  end

  // digit and binary registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg   <= word_neg;
      dec   <= (func == FUNC_DEC);
      upper <= (func != FUNC_HEX_LOWER);
      if (func == FUNC_DEC) begin
        bin    <= mag;
        digits <= '0;
      end else begin
        bin    <= '0;
        digits <= DIG_BITS'(word);
      end
    end else if (ctl.step) begin
      // shift the adjusted digits up one bit, next binary bit comes in below;
      // the top bit of the top digit is never set for this word width
      digits <= {adj[NDIG-1][2:0], adj[NDIG-2:0], bin[WORD_BITS-1]};
      bin    <= {bin[WORD_BITS-2:0], 1'b0};
    end else if (ctl.shift) begin
      digits <= {digits[NDIG-2:0], 4'd0};
    end
    if (rst) begin
      neg   <= 1'b0;
      dec   <= 1'b0;
      upper <= 1'b0;
    end
  end

  assign top_nib       = digits[NDIG-1];
  assign stat.dec      = dec;
  assign stat.neg      = neg;
  assign stat.top_zero = (digits[NDIG-1] == 4'd0);

endmodule

// ----- rtl/i2a_seq.sv -----
// i2a_seq: sequencer that runs the conversion steps, skips leading zeros
// and hands characters to the output register. Depends on i2a_pkg.
module i2a_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_free,
  input  i2a_pkg::stat_t stat,
  output logic           busy,
  output i2a_pkg::ctl_t  ctl
);
  import i2a_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] steps, steps_next;
  logic [REM_W-1:0]  remain, remain_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      steps  <= '0;
      remain <= '0;
    end else begin
      state  <= state_next;
      steps  <= steps_next;
      remain <= remain_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    steps_next  = steps;
    remain_next = remain;
    ctl         = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load    = 1'b1;
          steps_next  = STEP_W'(WORD_BITS);
          remain_next = REM_W'(NDIG);
          state_next  = ST_CONV;
        end
      end
      ST_CONV: begin
        // hex words skip the bcd steps; digit register is already loaded
        if (stat.dec) begin
          ctl.step = 1'b1;
        end
        steps_next = steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          state_next = stat.neg ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          ctl.out_load  = 1'b1;
          ctl.out_minus = 1'b1;
          state_next    = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && remain > REM_W'(1)) begin
          ctl.shift   = 1'b1;
          remain_next = remain - 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_last = (remain == REM_W'(1));
          ctl.shift    = 1'b1;
          remain_next  = remain - 1'b1;
          if (remain == REM_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- rtl/integer_to_ascii_formatter.sv -----
// integer_to_ascii_formatter: top level, digit unit, sequencer and output
// register. Depends on i2a_pkg, i2a_conv and i2a_seq.
//
//  channel | signals                                  | dir
//  in      | in_valid, in_stall, func, value_bits     | in beat, stall driven here
//  out     | out_valid, out_stall, char_code, last    | out beat, one char per beat
//
// one word goes through its accept, a shift-add-3 step for each magnitude bit
// (hex words just hold their nibbles), a minus sign if negative, then leading
// zero skip and characters together; each character also waits while
// out_stall holds the output register.
// in_stall is high from accept until the last character is in the output
// register. rst is synchronous and clears sequencer and output valid.
module integer_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  char_code,
  output logic        last
);
  import i2a_pkg::*;

  ctl_t       ctl;
  stat_t      stat;
  logic [3:0] top_nib;
  logic       upper;
  logic       busy;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy;

  i2a_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .busy     (busy),
    .ctl      (ctl)
  );

  i2a_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .func       (func),
    .value_bits (value_bits),
    .stat       (stat),
    .top_nib    (top_nib),
    .upper      (upper)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (ctl.out_load) begin
      char_code <= ctl.out_minus ? CH_MINUS : digit_char(top_nib, upper);
      last      <= ctl.out_last;
    end
  end

  // accepted word keeps the input closed on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after accept");

  // more characters pending means no new word is taken
  a_pending_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> in_stall)
    else $error("input open while characters pending");

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_code == CH_MINUS) |-> !last)
    else $error("minus sign flagged as last");

endmodule
